// ===== design/bsm_pkg.sv =====
package bsm_pkg;

	localparam int DEFAULT_WIDTH = 8;

	typedef logic [1:0] booth_pair_t;

	localparam booth_pair_t BOOTH_SUB = 2'b10;
	localparam booth_pair_t BOOTH_ADD = 2'b01;

endpackage

// ===== design/bsm_if.sv =====
interface bsm_operand_if #(
	parameter int WIDTH = bsm_pkg::DEFAULT_WIDTH
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] multiplicand;
	logic signed [WIDTH-1:0] multiplier;

	modport source (output valid, output multiplicand, output multiplier, input ready);
	modport sink (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface bsm_product_if #(
	parameter int WIDTH = bsm_pkg::DEFAULT_WIDTH
);
	logic                      valid;
	logic                      ready;
	logic signed [2*WIDTH-1:0] product;

	modport source (output valid, output product, input ready);
	modport sink (input valid, input product, output ready);
endinterface

// ===== design/booth_signed_multiplier.sv =====
// Signed radix-2 Booth multiplier: takes two WIDTH-bit two's complement operands and
// returns their exact 2*WIDTH-bit product. The WIDTH Booth steps are laid out as WIDTH
// pipeline stages, one add/subtract of WIDTH+1 bits each, so a new item is accepted every
// cycle unless a stalled output has filled every stage; its product is offered from the
// registers of the last stage. A stalled output holds the pipeline back stage by stage;
// empty stages still fill, so bubbles are squeezed out.
module booth_signed_multiplier #(
	parameter int WIDTH = bsm_pkg::DEFAULT_WIDTH
) (
	input logic            clk,
	input logic            arst_n,
	bsm_operand_if.sink    operands,
	bsm_product_if.source  result
);
	import bsm_pkg::*;

	logic                    v_s  [1:WIDTH];
	logic                    rdy  [1:WIDTH];
	logic signed [WIDTH:0]   a_s  [1:WIDTH];
	logic [WIDTH-1:0]        q_s  [1:WIDTH];
	logic                    qp_s [1:WIDTH-1];
	logic signed [WIDTH-1:0] m_s  [1:WIDTH-1];

	for (genvar k = 1; k <= WIDTH; k++) begin : g_stage
		logic signed [WIDTH:0]   a_src;
		logic [WIDTH-1:0]        q_src;
		logic                    qp_src;
		logic signed [WIDTH-1:0] m_src;
		logic                    v_src;
		logic signed [WIDTH:0]   m_ext;
		logic signed [WIDTH:0]   sum;

		if (k == 1) begin : g_first
			assign a_src  = '0;
			assign q_src  = operands.multiplier;
			assign qp_src = 1'b0;
			assign m_src  = operands.multiplicand;
			assign v_src  = operands.valid;
		end else begin : g_next
			assign a_src  = a_s[k-1];
			assign q_src  = q_s[k-1];
			assign qp_src = qp_s[k-1];
			assign m_src  = m_s[k-1];
			assign v_src  = v_s[k-1];
		end

		if (k == WIDTH) begin : g_rdy_last
			assign rdy[k] = !v_s[k] || result.ready;
		end else begin : g_rdy_mid
			assign rdy[k] = !v_s[k] || rdy[k+1];
		end

		assign m_ext = {m_src[WIDTH-1], m_src};

		always_comb begin
			case ({q_src[0], qp_src})
				BOOTH_SUB: sum = a_src - m_ext;
				BOOTH_ADD: sum = a_src + m_ext;
				default:   sum = a_src;
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_src;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_src) begin
				a_s[k] <= sum >>> 1;
				q_s[k] <= {sum[0], q_src[WIDTH-1:1]};
			end
		end

		if (k < WIDTH) begin : g_carry
			always_ff @(posedge clk) begin
				if (rdy[k] && v_src) begin
					qp_s[k] <= q_src[0];
					m_s[k]  <= m_src;
				end
			end
		end
	end

	assign operands.ready = rdy[1];
	assign result.valid   = v_s[WIDTH];
	assign result.product = {a_s[WIDTH][WIDTH-1:0], q_s[WIDTH]};

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		operands.valid && operands.ready |=> v_s[1])
		else $error("accepted item did not enter the first stage");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[WIDTH] && !result.ready |=> v_s[WIDTH] && $stable(a_s[WIDTH]) && $stable(q_s[WIDTH]))
		else $error("output stage changed while stalled");

	a_top_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[WIDTH] |-> a_s[WIDTH][WIDTH] == a_s[WIDTH][WIDTH-1])
		else $error("product overflowed its 2*WIDTH bits");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!operands.ready |-> v_s[1] && v_s[WIDTH] && !result.ready)
		else $error("input stalled while the pipeline had room");

endmodule
